### rtl/age_quartile_summarizer_defines.svh
// Assertion helpers for the quartile summarizer.
`ifndef AGE_QUARTILE_SUMMARIZER_DEFINES_SVH
`define AGE_QUARTILE_SUMMARIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AQS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define AQS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/aqs_pkg.sv
package aqs_pkg;

   localparam int AGE_W     = 8;
   localparam int MEMBERS_W = 9;
   localparam int QUART_W   = 2;

   localparam logic [QUART_W-1:0] LAST_QUARTILE = 2'd3;

   typedef struct packed {
      logic [AGE_W-1:0] age;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [QUART_W-1:0]   quartile;
      logic [MEMBERS_W-1:0] members;
      logic [AGE_W-1:0]     youngest;
      logic [AGE_W-1:0]     oldest;
      logic                 final_res;
   } rsp_type;

   typedef struct packed {
      logic             insert;
      logic             drain;
      logic [AGE_W-1:0] age;
   } chain_ctl_type;

endpackage

### rtl/age_quartile_summarizer.sv
// Quartile summarizer over a set of ages.
// req channel: one age per transaction; last = 1 closes the set.
// rsp channel: four transactions per set, quartile 0..3, final_res on the fourth.
// Ages are kept sorted in a chain of MAX_ITEMS insertion cells; every age,
// the last one too, is placed as it is accepted, so a set streams in at one age per cycle.
// Ages beyond MAX_ITEMS are dropped; a dropped age's last flag still closes the set.
// After the last age the chain shifts out through cell 0, one age per cycle,
// and the quartile bounds are captured as it does.
// The four results then follow, one per cycle while rsp_ready is high.
// req_ready is low from the last age until the fourth result is taken.
// A stalled receiver holds the current result; nothing is lost or repeated.
// Reset empties the chain and returns to collecting; no clearing pass is needed.
`include "age_quartile_summarizer_defines.svh"

module age_quartile_summarizer import aqs_pkg::*; #(
   parameter int MAX_ITEMS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   chain_ctl_type    ctl;
   logic             valid_c [MAX_ITEMS];
   logic [AGE_W-1:0] age_c   [MAX_ITEMS];

   aqs_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .head_age  (age_c[0]),
      .ctl       (ctl)
   );

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic             pv, nv;
      logic [AGE_W-1:0] pa, na;

      if (i == 0) begin : g_first
         assign pv = 1'b1;
         assign pa = '0;
      end else begin : g_mid
         assign pv = valid_c[i-1];
         assign pa = age_c[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_top
         assign nv = 1'b0;
         assign na = '0;
      end else begin : g_low
         assign nv = valid_c[i+1];
         assign na = age_c[i+1];
      end

      aqs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (pv),
         .prev_age   (pa),
         .next_valid (nv),
         .next_age   (na),
         .cell_valid (valid_c[i]),
         .cell_age   (age_c[i])
      );
   end

   `AQS_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready)
   `AQS_ASSERT_NOW(a_final_last, rsp_valid && rsp_data.final_res, rsp_data.quartile == LAST_QUARTILE)
   `AQS_ASSERT_NEXT(a_quart_seq, rsp_valid && rsp_ready && !rsp_data.final_res, rsp_valid && (rsp_data.quartile == $past(rsp_data.quartile) + 2'd1))
   `AQS_ASSERT_NEXT(a_end_set, rsp_valid && rsp_ready && rsp_data.final_res, req_ready && !rsp_valid)

endmodule

### rtl/aqs_cell.sv
module aqs_cell import aqs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  chain_ctl_type    ctl,
   input  logic             prev_valid,
   input  logic [AGE_W-1:0] prev_age,
   input  logic             next_valid,
   input  logic [AGE_W-1:0] next_age,
   output logic             cell_valid,
   output logic [AGE_W-1:0] cell_age
);

   logic             valid_ff, valid_in;
   logic [AGE_W-1:0] age_ff, age_in;

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      if (ctl.drain) begin
         valid_in = next_valid;
         age_in   = next_age;
      end else if (ctl.insert) begin
         if (prev_valid && (prev_age > ctl.age)) begin
            // larger neighbor moves up one place
            valid_in = 1'b1;
            age_in   = prev_age;
         end else if (prev_valid && (!valid_ff || (age_ff > ctl.age))) begin
            valid_in = 1'b1;
            age_in   = ctl.age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      age_ff <= age_in;
   end

   assign cell_valid = valid_ff;
   assign cell_age   = age_ff;

endmodule

### rtl/aqs_ctrl.sv
module aqs_ctrl import aqs_pkg::*; #(
   parameter int MAX_ITEMS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic [AGE_W-1:0] head_age,
   output chain_ctl_type    ctl
);

   localparam int CW = $clog2(MAX_ITEMS + 1);

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_DRAIN   = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      cnt_ff, rem_ff, wc_ff;
   logic [QUART_W-1:0] qi_ff, e_ff;
   logic [AGE_W-1:0]   lo_ff [4];
   logic [AGE_W-1:0]   hi_ff [4];

   logic          accept, full, do_ins;
   logic [CW-1:0] n_in, q_in, q_cur, three_q, tail_sz, sz;

   assign req_ready = (state_ff == ST_COLLECT);
   assign accept    = req_valid && req_ready;
   assign full      = (cnt_ff == CW'(MAX_ITEMS));
   assign do_ins    = accept && !full;
   assign n_in      = cnt_ff + CW'(do_ins);
   assign q_in      = n_in >> 2;
   assign q_cur     = cnt_ff >> 2;
   assign three_q   = q_cur + (q_cur << 1);
   assign tail_sz   = cnt_ff - three_q;
   assign sz        = (qi_ff == LAST_QUARTILE) ? tail_sz : q_cur;

   assign ctl.insert = do_ins;
   assign ctl.drain  = (state_ff == ST_DRAIN) && (rem_ff != '0);
   assign ctl.age    = req_data.age;

   assign rsp_valid          = (state_ff == ST_EMIT);
   assign rsp_data.quartile  = e_ff;
   assign rsp_data.members   = MEMBERS_W'((e_ff == LAST_QUARTILE) ? tail_sz : q_cur);
   assign rsp_data.youngest  = lo_ff[e_ff];
   assign rsp_data.oldest    = hi_ff[e_ff];
   assign rsp_data.final_res = (e_ff == LAST_QUARTILE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         wc_ff    <= '0;
         qi_ff    <= '0;
         e_ff     <= '0;
      end else begin
         unique case (state_ff)
            ST_COLLECT: begin
               if (accept) begin
                  cnt_ff <= n_in;
                  if (req_data.last) begin
                     state_ff <= ST_DRAIN;
                     rem_ff   <= n_in;
                     wc_ff    <= '0;
                     qi_ff    <= (q_in == '0) ? LAST_QUARTILE : '0;
                  end
               end
            end
            ST_DRAIN: begin
               if (rem_ff == '0) begin
                  state_ff <= ST_EMIT;
                  e_ff     <= '0;
               end else begin
                  rem_ff <= rem_ff - CW'(1);
                  if ((wc_ff == sz - CW'(1)) && (qi_ff != LAST_QUARTILE)) begin
                     qi_ff <= qi_ff + QUART_W'(1);
                     wc_ff <= '0;
                  end else begin
                     wc_ff <= wc_ff + CW'(1);
                  end
               end
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  if (e_ff == LAST_QUARTILE) begin
                     state_ff <= ST_COLLECT;
                     cnt_ff   <= '0;
                  end else begin
                     e_ff <= e_ff + QUART_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_COLLECT;
            end
         endcase
      end
   end

   // quartile bounds, captured as the chain shifts out through cell 0
   always_ff @(posedge clock) begin
      if (accept && req_data.last) begin
         for (int k = 0; k < 4; k++) begin
            lo_ff[k] <= '0;
            hi_ff[k] <= '0;
         end
      end else if (ctl.drain) begin
         if (wc_ff == '0) begin
            lo_ff[qi_ff] <= head_age;
         end
         if (wc_ff == sz - CW'(1)) begin
            hi_ff[qi_ff] <= head_age;
         end
      end
   end

endmodule
